/* rtl/cxd_pkg.sv */
package cxd_pkg;

	// Default size of the payload store in bytes.
	localparam int BUFFER_BYTES_DEF = 64;

	// Frame delimiter on the wire.
	localparam logic [7:0] DELIM = 8'h00;

	// Code byte that opens a full group with no implicit zero.
	localparam logic [7:0] CODE_FULL = 8'hFF;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_PAYLOAD  = 2'd0,
		ST_CHECKSUM = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_FORMAT   = 2'd3
	} status_t;

	// End-of-frame request from the decoder to the emitter.
	typedef struct packed {
		logic    valid;
		logic    is_err;
		status_t status;
	} cmd_t;

endpackage

/* rtl/cxd_store.sv */
module cxd_store import cxd_pkg::*; #(
	parameter int DEPTH = BUFFER_BYTES_DEF,
	parameter int AW    = $clog2(BUFFER_BYTES_DEF)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/cxd_decode.sv */
module cxd_decode import cxd_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	parameter int CNT_W        = $clog2(BUFFER_BYTES_DEF)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  logic [7:0]       rx_byte,
	output logic             wr_en,
	output logic [CNT_W-1:0] wr_addr,
	output logic [7:0]       wr_data,
	output cmd_t             cmd,
	output logic [CNT_W-1:0] len
);

	localparam logic [CNT_W-1:0] ENC_LIMIT = CNT_W'(BUFFER_BYTES - 1);

	logic [CNT_W-1:0] wr_cnt_q;
	logic [CNT_W-1:0] enc_cnt_q;
	logic [7:0]       code_rem_q;
	logic             zero_pend_q;
	logic [7:0]       xor_q;
	logic             discard_q;

	logic is_delim;
	logic overflow;

	assign is_delim = (rx_byte == DELIM);
	assign overflow = (enc_cnt_q == ENC_LIMIT);

	// Store write: a pending zero on a code byte, or a data byte as it is.
	always_comb begin
		wr_en   = 1'b0;
		wr_data = rx_byte;
		if (acc && !is_delim && !discard_q && !overflow) begin
			if (code_rem_q == 8'd0) begin
				wr_en   = zero_pend_q;
				wr_data = 8'd0;
			end else begin
				wr_en = 1'b1;
			end
		end
	end
	assign wr_addr = wr_cnt_q;
	assign len     = CNT_W'(wr_cnt_q - 1'b1);

	// End-of-frame and overflow requests to the emitter.
	always_comb begin
		cmd = '{valid: 1'b0, is_err: 1'b0, status: ST_PAYLOAD};
		if (acc && !discard_q) begin
			if (is_delim) begin
				cmd.valid = 1'b1;
				priority if (code_rem_q != 8'd0) begin
					cmd.is_err = 1'b1;
					cmd.status = ST_FORMAT;
				end else if (wr_cnt_q < CNT_W'(2) || xor_q != 8'd0) begin
					cmd.is_err = 1'b1;
					cmd.status = ST_CHECKSUM;
				end else begin
					cmd.is_err = 1'b0;
				end
			end else if (overflow) begin
				cmd.valid  = 1'b1;
				cmd.is_err = 1'b1;
				cmd.status = ST_OVERFLOW;
			end
		end
	end

	// Frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt_q    <= '0;
			enc_cnt_q   <= '0;
			code_rem_q  <= 8'd0;
			zero_pend_q <= 1'b0;
			xor_q       <= 8'd0;
			discard_q   <= 1'b0;
		end else if (acc) begin
			if (is_delim || (!discard_q && overflow)) begin
				wr_cnt_q    <= '0;
				enc_cnt_q   <= '0;
				code_rem_q  <= 8'd0;
				zero_pend_q <= 1'b0;
				xor_q       <= 8'd0;
				discard_q   <= !is_delim;
			end else if (!discard_q) begin
				enc_cnt_q <= CNT_W'(enc_cnt_q + 1'b1);
				if (wr_en) begin
					wr_cnt_q <= CNT_W'(wr_cnt_q + 1'b1);
					xor_q    <= xor_q ^ wr_data;
				end
				if (code_rem_q == 8'd0) begin
					code_rem_q  <= rx_byte - 8'd1;
					zero_pend_q <= (rx_byte != CODE_FULL);
				end else begin
					code_rem_q <= code_rem_q - 8'd1;
				end
			end
		end
	end

endmodule

/* rtl/cxd_emit.sv */
module cxd_emit import cxd_pkg::*; #(
	parameter int CNT_W = $clog2(BUFFER_BYTES_DEF)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [CNT_W-1:0] len,
	output logic             rd_en,
	output logic [CNT_W-1:0] rd_addr,
	input  logic [7:0]       rd_data,
	output logic             idle,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       data,
	output status_t          status,
	output logic             last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ERR,
		S_RD,
		S_LD
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] len_q;
	status_t          err_q;
	logic             out_valid_q;
	logic [7:0]       data_q;
	status_t          status_q;
	logic             last_q;

	logic out_free;
	logic is_final;

	// The output register can take a new result at this edge.
	assign out_free = !out_valid_q || out_ready;
	assign is_final = (CNT_W'(idx_q + 1'b1) == len_q);

	assign rd_en   = (state_q == S_RD) && out_free;
	assign rd_addr = idx_q;
	assign idle    = (state_q == S_IDLE);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			len_q       <= '0;
			err_q       <= ST_PAYLOAD;
			out_valid_q <= 1'b0;
			data_q      <= 8'd0;
			status_q    <= ST_PAYLOAD;
			last_q      <= 1'b0;
		end else begin
			// The loading states set the valid flag themselves.
			if (out_valid_q && out_ready && state_q != S_ERR && state_q != S_LD) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						err_q   <= cmd.status;
						len_q   <= len;
						idx_q   <= '0;
						state_q <= cmd.is_err ? S_ERR : S_RD;
					end
				end
				S_ERR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						data_q      <= 8'd0;
						status_q    <= err_q;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_RD: begin
					if (out_free) begin
						state_q <= S_LD;
					end
				end
				S_LD: begin
					out_valid_q <= 1'b1;
					data_q      <= rd_data;
					status_q    <= ST_PAYLOAD;
					last_q      <= is_final;
					idx_q       <= CNT_W'(idx_q + 1'b1);
					state_q     <= is_final ? S_IDLE : S_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

/* rtl/cobs_xor_deframer_top.sv */
// Receive deframer for COBS frames with a trailing XOR checksum. One encoded byte
// is taken per request; zero ends a frame. Bytes are decoded as they arrive and
// written into a payload store of BUFFER_BYTES entries; the block takes a byte
// in every cycle while it is idle. A delimiter of a good frame starts a walk
// over the store that gives the payload bytes in order, each by a memory read
// and then a load of the output register; input is held off until the walk
// ends, and stalls of the sink make the walk longer. Checksum, overflow and
// format errors each give a single result with last set, after which input
// resumes. A frame that carries BUFFER_BYTES or more encoded bytes before its
// delimiter reports overflow once, at its byte number BUFFER_BYTES, and the
// rest of that frame up to its delimiter is dropped.
module cobs_xor_deframer_top import cxd_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data,
	output logic [1:0] status,
	output logic       last
);

	localparam int CNT_W = $clog2(BUFFER_BYTES);

	logic             acc;
	logic             wr_en;
	logic [CNT_W-1:0] wr_addr;
	logic [7:0]       wr_data;
	logic             rd_en;
	logic [CNT_W-1:0] rd_addr;
	logic [7:0]       rd_data;
	cmd_t             cmd;
	logic [CNT_W-1:0] len;
	logic             idle;
	status_t          status_e;

	// Input is taken only while no frame is being emitted.
	assign in_ready = idle;
	assign acc      = in_valid && in_ready;

	cxd_decode #(
		.BUFFER_BYTES (BUFFER_BYTES),
		.CNT_W        (CNT_W)
	) u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.rx_byte (rx_byte),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.cmd     (cmd),
		.len     (len)
	);

	cxd_store #(
		.DEPTH (BUFFER_BYTES),
		.AW    (CNT_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	cxd_emit #(
		.CNT_W (CNT_W)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.len       (len),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.idle      (idle),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data      (data),
		.status    (status_e),
		.last      (last)
	);

	assign status = status_e;

	// The store is written only for an accepted byte.
	assert property (@(posedge clk) disable iff (!arst_n) wr_en |-> acc)
		else $error("store written without an accepted byte");

	// A store write and an end-of-frame request never come from the same byte.
	assert property (@(posedge clk) disable iff (!arst_n) !(wr_en && cmd.valid))
		else $error("store write and frame request from one byte");

	// Error results carry zero data and close the run.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status_e != ST_PAYLOAD |-> last && data == 8'd0)
		else $error("error result without last or with nonzero data");

	// Emission reads never overlap with accepted input.
	assert property (@(posedge clk) disable iff (!arst_n) rd_en |-> !acc)
		else $error("store read while input is accepted");

endmodule

/* tb/cobs_xor_deframer_top_tb.sv */
module cobs_xor_deframer_top_tb;
	import cxd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUF_BYTES = BUFFER_BYTES_DEF;
	localparam int RANDOM_BYTES = 360;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 300;
	localparam int PRINT_CAP = 40;

	typedef logic [7:0] octets_t[$];

	typedef struct {
		logic [7:0] data;
		status_t    status;
		logic       last;
	} result_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = DELIM;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] data;
	logic [1:0] status;
	logic       last;

	// Encoded bytes waiting to be offered, and decoded results still owed by the block.
	octets_t wire_bytes_q;
	result_t pending_results[$];

	// Decoder state mirrored in the testbench.
	logic [7:0] dec_store [BUF_BYTES];
	logic [6:0] dec_len;
	logic [6:0] enc_len;
	logic [7:0] group_left;
	logic       zero_owed;
	logic [7:0] sum_acc;
	logic       dropping;

	int err_cnt = 0;
	int src_gap, src_calm;
	int sink_wait, sink_calm, sink_taken;
	logic hold_done;
	int idle_cycles = 0;

	cobs_xor_deframer_top #(
		.BUFFER_BYTES(BUF_BYTES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data     (data),
		.status   (status),
		.last     (last)
	);

	// 50 MHz clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic report_mismatch(input string msg);
		err_cnt++;
		if (err_cnt <= PRINT_CAP) begin
			$display("ERROR @%0t: %s", $realtime, msg);
		end
	endtask

	// Random idle length: mostly short, a few long, with calm stretches of no idling.
	function automatic int next_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
		end
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void clear_frame();
		dec_len = '0;
		enc_len = '0;
		group_left = '0;
		zero_owed = 1'b0;
		sum_acc = '0;
	endfunction

	function automatic void owe_result(input logic [7:0] d, input status_t st,
			input logic lst);
		result_t r;
		r.data = d;
		r.status = st;
		r.last = lst;
		pending_results.push_back(r);
	endfunction

	function automatic void keep_decoded(input logic [7:0] b);
		dec_store[dec_len[5:0]] = b;
		dec_len = dec_len + 7'd1;
		sum_acc = sum_acc ^ b;
	endfunction

	// Decodes one accepted byte and queues the results it is owed.
	function automatic void decode_rx_byte(input logic [7:0] b);
		if (b == DELIM) begin
			if (dropping) begin
				dropping = 1'b0;
			end else if (group_left != 8'd0) begin
				owe_result(8'h00, ST_FORMAT, 1'b1);
			end else if (dec_len < 7'd2 || sum_acc != 8'h00) begin
				owe_result(8'h00, ST_CHECKSUM, 1'b1);
			end else begin
				// The checksum byte at the end is not sent on.
				for (int i = 0; i < int'(dec_len) - 1; i++) begin
					owe_result(dec_store[i % BUF_BYTES], ST_PAYLOAD,
						i == int'(dec_len) - 2);
				end
			end
			clear_frame();
		end else if (!dropping) begin
			if (int'(enc_len) + 1 >= BUF_BYTES) begin
				clear_frame();
				dropping = 1'b1;
				owe_result(8'h00, ST_OVERFLOW, 1'b1);
			end else begin
				enc_len = enc_len + 7'd1;
				if (group_left == 8'd0) begin
					// Code byte: the zero that closed the previous group goes in first.
					if (zero_owed) begin
						keep_decoded(8'h00);
					end
					group_left = b - 8'd1;
					zero_owed = (b != CODE_FULL);
				end else begin
					keep_decoded(b);
					group_left = group_left - 8'd1;
				end
			end
		end
	endfunction

	task automatic send_raw(input octets_t b);
		foreach (b[i]) begin
			wire_bytes_q.push_back(b[i]);
		end
	endtask

	// Appends the checksum, COBS-encodes the frame and closes it with a delimiter.
	task automatic send_frame(input octets_t body, input bit bad_sum);
		octets_t full;
		octets_t grp;
		logic [7:0] sum;
		sum = 8'h00;
		full = body;
		foreach (body[i]) begin
			sum = sum ^ body[i];
		end
		if (bad_sum) begin
			sum = sum ^ 8'($urandom_range(1, 255));
		end
		full.push_back(sum);
		foreach (full[i]) begin
			if (full[i] == 8'h00) begin
				wire_bytes_q.push_back(8'(grp.size() + 1));
				send_raw(grp);
				grp = {};
			end else begin
				grp.push_back(full[i]);
			end
		end
		wire_bytes_q.push_back(8'(grp.size() + 1));
		send_raw(grp);
		wire_bytes_q.push_back(DELIM);
	endtask

	// Short directed frames for each error kind and the field extremes, then one overflow.
	task automatic fill_directed();
		octets_t body;
		send_raw({DELIM});
		send_raw({8'h02, 8'h05, DELIM});
		send_raw({8'h01, DELIM});
		send_frame({8'hFF, 8'h00}, 1'b0);
		send_frame({8'h80}, 1'b1);
		send_raw({8'h03, 8'h11, DELIM});
		send_raw({CODE_FULL, 8'h01, DELIM});
		send_frame({8'h00, 8'h00}, 1'b0);
		for (int i = 0; i < BUF_BYTES + 2; i++) begin
			body.push_back(8'($urandom_range(1, 255)));
		end
		body.push_back(DELIM);
		send_raw(body);
	endtask

	// Mostly well-formed frames with random content, plus broken frames and noise.
	task automatic fill_random();
		octets_t body;
		int taken, start, kind, len, cut, n;
		taken = 0;
		while (taken < RANDOM_BYTES) begin
			start = wire_bytes_q.size();
			kind = $urandom_range(0, 99);
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, BUF_BYTES - 3)
				: $urandom_range(0, 10);
			if (kind >= 82 && kind < 88) begin
				len = $urandom_range(BUF_BYTES - 2, BUF_BYTES + 10);
			end
			body = {};
			for (int i = 0; i < len; i++) begin
				body.push_back(($urandom_range(0, 3) == 0) ? 8'h00
					: 8'($urandom_range(0, 255)));
			end
			if (kind < 62) begin
				send_frame(body, 1'b0);
			end else if (kind < 74) begin
				send_frame(body, 1'b1);
			end else if (kind < 82) begin
				// Cut the frame short so that it most likely ends inside a group.
				send_frame(body, 1'b0);
				void'(wire_bytes_q.pop_back());
				cut = $urandom_range(1, wire_bytes_q.size() - start - 1);
				repeat (cut) void'(wire_bytes_q.pop_back());
				wire_bytes_q.push_back(DELIM);
			end else if (kind < 88) begin
				send_frame(body, 1'($urandom_range(0, 1)));
			end else begin
				n = $urandom_range(0, 8);
				repeat (n) wire_bytes_q.push_back(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1) == 1) begin
					wire_bytes_q.push_back(DELIM);
				end
			end
			n = wire_bytes_q.size() - start;
			// Bytes dropped after an overflow do not count.
			taken += (kind >= 82 && kind < 88) ? BUF_BYTES : n;
		end
		wire_bytes_q.push_back(DELIM);
	endtask

	// Request driver: takes the next encoded byte once the current one is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= DELIM;
			src_gap = 0;
			src_calm = 0;
		end else if (!in_valid || in_ready) begin
			if (src_gap > 0) begin
				src_gap--;
				in_valid <= 1'b0;
			end else if (wire_bytes_q.size() != 0) begin
				in_valid <= 1'b1;
				rx_byte <= wire_bytes_q.pop_front();
				src_gap = next_gap(src_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result sink with random stalls and one long hold-off while a result is waiting.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_wait = 0;
			sink_calm = 0;
			sink_taken = 0;
			hold_done = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				sink_taken++;
			end
			if (sink_wait > 0) begin
				sink_wait--;
				out_ready <= 1'b0;
			end else if (!hold_done && sink_taken >= 80 && out_valid) begin
				hold_done = 1'b1;
				sink_wait = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) begin
					sink_wait = next_gap(sink_calm);
				end
			end
		end
	end

	// Monitor: predict on each accepted byte first, then check each accepted result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			dropping = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				decode_rx_byte(rx_byte);
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result data=%02h status=%0d last=%0b",
						data, status, last));
				end else if (data !== pending_results[0].data
						|| status !== pending_results[0].status
						|| last !== pending_results[0].last) begin
					report_mismatch($sformatf(
						"result data=%02h status=%0d last=%0b, expected %02h %0d %0b",
						data, status, last, pending_results[0].data,
						pending_results[0].status, pending_results[0].last));
					void'(pending_results.pop_front());
				end else begin
					void'(pending_results.pop_front());
				end
			end
		end
	end

	// Watchdog on cycles in which no request and no result moves.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Stimulus setup, reset, and end of run.
	initial begin
		arst_n = 1'b0;
		fill_directed();
		fill_random();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		do begin
			@(negedge clk);
		end while (wire_bytes_q.size() != 0 || in_valid || pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
